// File: hdl/vnsl_pkg.sv
package vnsl_pkg;

  // Table depth used when the top level is not given another.
  localparam int unsigned MAX_SITES_DEF = 64;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned PIXEL_W = 11;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned CODE_W  = 9;

  // Absolute difference fits 12 bits (pixel 0..2047 against site -2048..2047).
  localparam int unsigned ABS_W  = 12;
  localparam int unsigned SQ_W   = 2 * ABS_W;
  localparam int unsigned DIST_W = SQ_W + 1;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CODE_W-1:0]  EMPTY_CODE  = 9'h1FF;
  localparam logic [LABEL_W-1:0] EMPTY_LABEL = 8'hFF;

  typedef struct packed {
    logic [LABEL_W-1:0]        label;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } site_t;

  typedef struct packed {
    logic [DIST_W-1:0]  sq_dist;
    logic [LABEL_W-1:0] label;
  } dist_res_t;

endpackage

// File: hdl/voronoi_nearest_site_labeler.sv
// Nearest-site labeler for Voronoi region rendering.
// One input channel (in_valid_i / in_ready_o) carries command words: append a
// site, clear the site table, or query a pixel. One output channel
// (out_valid_o / out_ready_i) carries one result word per query and nothing
// for the other commands. Appends and clears complete in the idle state, and
// the block is ready again in the next cycle. A query walks the site table in
// insertion order, one site per cycle through a shared distance unit (read,
// absolute difference, square, sum) followed by a compare against the best
// so far. When the last site has left the distance unit, the query moves to
// its final state and loads the result word into the output register. The
// block is not ready while a query is in progress.
// Results sit in an output register: the next command word is accepted while
// a result still waits to be taken. A query that finishes while the receiver
// stalls holds in its final state until the output register frees up.
// Reset empties the site table and clears the remembered line label; table
// contents are not cleared, since entries beyond the fill count are never read.
module voronoi_nearest_site_labeler #(
  parameter int unsigned MAX_SITES = vnsl_pkg::MAX_SITES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [vnsl_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [vnsl_pkg::COORD_W-1:0] site_x_i,
  input  logic signed [vnsl_pkg::COORD_W-1:0] site_y_i,
  input  logic [vnsl_pkg::LABEL_W-1:0]       site_label_i,
  input  logic [vnsl_pkg::PIXEL_W-1:0]       pixel_x_i,
  input  logic [vnsl_pkg::PIXEL_W-1:0]       pixel_y_i,
  input  logic                               line_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [vnsl_pkg::LABEL_W-1:0]       nearest_label_o,
  output logic                               no_site_o,
  output logic                               on_border_o
);
  import vnsl_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SITES + 1);
  localparam int unsigned IdxW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    issue_q, issue_d;
  logic               rd_vld_q;
  logic               found_q, found_d;
  logic [CODE_W-1:0]  prev_q, prev_d;
  logic               out_valid_q, out_valid_d;

  logic [PIXEL_W-1:0] px_q, py_q;
  logic               line_start_q;
  logic [DIST_W-1:0]  best_q;
  logic [LABEL_W-1:0] best_label_q;
  logic [LABEL_W-1:0] out_label_q;
  logic               out_no_site_q, out_border_q;

  site_t              site_mem_q [MAX_SITES];
  site_t              rd_site_q;
  site_t              wr_site;

  logic               in_fire, wr_en, rd_en, scan_done, load_out, take_best;
  logic               du_valid, du_busy;
  dist_res_t          du_res;
  logic [CODE_W-1:0]  code, prev_eff;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign wr_en      = in_fire & (opcode_i == OP_APPEND) & (cnt_q < CntW'(MAX_SITES));
  assign rd_en      = (state_q == ST_SCAN) & (issue_q < cnt_q);
  assign scan_done  = (state_q == ST_SCAN) & ~rd_en & ~rd_vld_q & ~du_busy;
  assign load_out   = (state_q == ST_DONE) & (~out_valid_q | out_ready_i);
  assign take_best  = du_valid & (~found_q | (du_res.sq_dist < best_q));

  assign wr_site.label = site_label_i;
  assign wr_site.y     = site_y_i;
  assign wr_site.x     = site_x_i;

  // The region code of an empty table is kept apart from every real label.
  assign code     = found_q ? {1'b0, best_label_q} : EMPTY_CODE;
  assign prev_eff = line_start_q ? '0 : prev_q;

  // Site table: one write port for appends, one registered read for the walk.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      site_mem_q[cnt_q[IdxW-1:0]] <= wr_site;
    end
    if (rd_en) begin
      rd_site_q <= site_mem_q[issue_q[IdxW-1:0]];
    end
  end

  vnsl_dist_unit u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (rd_vld_q),
    .pixel_x_i   (px_q),
    .pixel_y_i   (py_q),
    .site_i      (rd_site_q),
    .res_valid_o (du_valid),
    .res_o       (du_res),
    .busy_o      (du_busy)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    found_d     = found_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (opcode_i)
            OP_APPEND: begin
              if (wr_en) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            OP_QUERY: begin
              issue_d = '0;
              found_d = 1'b0;
              state_d = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_d = issue_q + 1'b1;
        end
        if (take_best) begin
          found_d = 1'b1;
        end
        if (scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          prev_d      = code;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_en;
      found_q     <= found_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Query operands, running best and the output word.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q         <= pixel_x_i;
      py_q         <= pixel_y_i;
      line_start_q <= line_start_i;
    end
    if (take_best) begin
      best_q       <= du_res.sq_dist;
      best_label_q <= du_res.label;
    end
    if (load_out) begin
      out_label_q   <= found_q ? best_label_q : EMPTY_LABEL;
      out_no_site_q <= ~found_q;
      out_border_q  <= (code != prev_eff);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_label_o = out_label_q;
  assign no_site_o       = out_no_site_q;
  assign on_border_o     = out_border_q;

  // The walk pipeline is empty whenever a new word can be taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!rd_vld_q && !du_busy))
    else $error("distance pipeline busy while idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CntW'(MAX_SITES)) && (issue_q <= cnt_q || state_q != ST_SCAN))
    else $error("site count or walk index out of range");

  a_no_site: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (no_site_o == ($past(cnt_q) == '0)))
    else $error("no-site flag disagrees with the table fill");

  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(cnt_q))
    else $error("site count changed during a table walk");

endmodule

// File: hdl/vnsl_dist_unit.sv
module vnsl_dist_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [vnsl_pkg::PIXEL_W-1:0]   pixel_x_i,
  input  logic [vnsl_pkg::PIXEL_W-1:0]   pixel_y_i,
  input  vnsl_pkg::site_t                site_i,
  output logic                           res_valid_o,
  output vnsl_pkg::dist_res_t            res_o,
  output logic                           busy_o
);
  import vnsl_pkg::*;

  // Three stages: absolute differences, squares, sum.
  logic signed [COORD_W:0] dx, dy;
  logic [ABS_W-1:0]        ax_q, ay_q;
  logic [LABEL_W-1:0]      lbl1_q, lbl2_q;
  logic [SQ_W-1:0]         sx_q, sy_q;
  logic                    v1_q, v2_q, v3_q;

  assign dx = $signed({2'b00, pixel_x_i}) - $signed({site_i.x[COORD_W-1], site_i.x});
  assign dy = $signed({2'b00, pixel_y_i}) - $signed({site_i.y[COORD_W-1], site_i.y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
    ay_q   <= dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    lbl1_q <= site_i.label;
    sx_q   <= ax_q * ax_q;
    sy_q   <= ay_q * ay_q;
    lbl2_q <= lbl1_q;
    res_o.sq_dist <= DIST_W'(sx_q) + DIST_W'(sy_q);
    res_o.label   <= lbl2_q;
  end

  assign res_valid_o = v3_q;
  assign busy_o      = v1_q | v2_q | v3_q;

endmodule
